[hdl/bthalloc_pkg.sv]
package bthalloc_pkg;

   localparam int HEAP_BYTES  = 65536;
   localparam int WORD_BYTES  = 4;
   localparam int DBL_BYTES   = 2 * WORD_BYTES;
   localparam int MIN_BLOCK   = 2 * DBL_BYTES;
   localparam int STORE_DEPTH = HEAP_BYTES / WORD_BYTES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int WORD_SHIFT  = $clog2(WORD_BYTES);
   localparam int TAG_W       = 18;
   localparam int OFF_W       = 20;
   localparam int REG_W       = 17;
   localparam int CSR_INDEX_W = 1;

   localparam logic [REG_W-1:0] CHUNK_RESET = 17'd4096;
   localparam logic [REG_W-1:0] LIMIT_RESET = 17'd65536;
   localparam logic [REG_W-1:0] HEAP_CAP    = REG_W'(HEAP_BYTES);

   // Layout left behind by reset: pad, prologue, one free chunk, epilogue.
   localparam logic [REG_W-1:0] INIT_BREAK = REG_W'(4 * WORD_BYTES) + CHUNK_RESET;
   localparam logic [TAG_W-1:0] TAG_PROLOGUE = TAG_W'(DBL_BYTES + 1);
   localparam logic [TAG_W-1:0] TAG_CHUNK    = TAG_W'(CHUNK_RESET);
   localparam logic [TAG_W-1:0] TAG_EPILOGUE = TAG_W'(1);
   localparam logic [ADDR_W-1:0] IDX_PRO_HDR  = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] IDX_PRO_FTR  = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] IDX_CHK_HDR  = ADDR_W'(3);
   localparam logic [ADDR_W-1:0] IDX_CHK_FTR  = ADDR_W'((INIT_BREAK - 8) / WORD_BYTES);
   localparam logic [ADDR_W-1:0] IDX_EPILOGUE = ADDR_W'((INIT_BREAK - 4) / WORD_BYTES);

   localparam logic [OFF_W-1:0] LIST_START = OFF_W'(DBL_BYTES);

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ZERO    = 2'd1;
   localparam logic [1:0] STATUS_NOSPACE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT = 1'd1;

   typedef struct packed {
      logic        func;
      logic [15:0] req_bytes;
      logic [15:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [15:0] payload_addr;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_FIT_CHK,
      S_FIT_TAG,
      S_GROW,
      S_GROW_W2,
      S_GROW_W3,
      S_MRG_RD1,
      S_MRG_RD2,
      S_MRG_RD3,
      S_MRG_EV,
      S_MRG_W2,
      S_MRG_DONE,
      S_PUT_RD,
      S_PUT_EV,
      S_PUT_W2,
      S_PUT_W3,
      S_PUT_W4,
      S_FREE_HDR,
      S_FREE_W2
   } state_type;

   function automatic logic [ADDR_W-1:0] word_idx(input logic [OFF_W-1:0] off);
      return off[ADDR_W+WORD_SHIFT-1:WORD_SHIFT];
   endfunction

endpackage

[hdl/bthalloc_ram.sv]
module bthalloc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

[hdl/boundary_tag_heap_allocator_core.sv]
// Channel   Ports                                  Handshake
// request   start, busy, req_data                  taken when start high and busy low
// result    rsp_valid, rsp_data                    one-cycle strobe, cannot be held off
// config    csr_we, csr_index, csr_wdata           written on an edge with csr_we high, not in reset
//
// After reset a clearing pass over all 16384 words writes the initial heap layout
// into the tag store; busy stays high during it. Tag accesses share the single port,
// and read data is used in the state after the one giving its address. A zero-size
// request or a free rejected by its address is answered at once; a valid free frees
// an allocated block and merges it with free neighbours. Allocation takes the first
// fit, grows the break if none fits, and splits off a remainder of 16 bytes or more.
// The result strobe comes with busy low, and a new word may be taken in that same cycle.
module boundary_tag_heap_allocator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  bthalloc_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   output bthalloc_pkg::rsp_type                rsp_data,
   input  logic                                 csr_we,
   input  logic [bthalloc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bthalloc_pkg::REG_W-1:0]       csr_wdata
);
   import bthalloc_pkg::*;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [REG_W-1:0]  brk_ff, brk_in;
   logic [REG_W-1:0]  chunk_ff, limit_ff;
   logic              op_ff, op_in;
   logic [REG_W-1:0]  asize_ff, asize_in;
   logic [OFF_W-1:0]  bp_ff, bp_in;
   logic [TAG_W-1:0]  sz_ff, sz_in;
   logic [TAG_W-1:0]  ptag_ff, ptag_in;
   logic [TAG_W-1:0]  bs_ff, bs_in;
   logic [TAG_W-1:0]  rem_ff, rem_in;
   logic              split_ff, split_in;
   logic [OFF_W-1:0]  w2addr_ff, w2addr_in;
   logic [TAG_W-1:0]  wval_ff, wval_in;
   logic [TAG_W-1:0]  gsize_ff, gsize_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [TAG_W-1:0]  mem_wdata;
   logic [TAG_W-1:0]  mem_rdata;
   logic [TAG_W-1:0]  rd_size;
   logic [TAG_W-1:0]  psize;
   logic [REG_W-1:0]  eff_lim;
   logic [REG_W-1:0]  grow_ext;
   logic [TAG_W-1:0]  grow_size;
   logic              grow_fail;
   logic [REG_W-1:0]  alloc_size;
   logic [OFF_W-1:0]  free_off;

   bthalloc_ram #(.WIDTH(TAG_W), .DEPTH(STORE_DEPTH)) u_tag_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rd_size  = {mem_rdata[TAG_W-1:3], 3'b000};
   assign psize    = {ptag_ff[TAG_W-1:3], 3'b000};
   assign eff_lim  = (limit_ff > HEAP_CAP) ? HEAP_CAP : limit_ff;
   assign grow_ext = (asize_ff > chunk_ff) ? asize_ff : chunk_ff;
   // Round the growth to an even number of words: bit 2 rounds up, bits 1:0 are dropped.
   assign grow_size = {1'b0, grow_ext[REG_W-1:3], 3'b000} +
                      (grow_ext[2] ? TAG_W'(DBL_BYTES) : '0);
   assign grow_fail = (grow_size == '0) || (grow_size > {1'b0, eff_lim}) ||
                      ({1'b0, brk_ff} > ({1'b0, eff_lim} - grow_size));
   assign alloc_size = (req_data.req_bytes <= 16'(DBL_BYTES)) ? REG_W'(MIN_BLOCK) :
                       (({1'b0, req_data.req_bytes} + REG_W'(2 * DBL_BYTES - 1)) &
                        ~REG_W'(DBL_BYTES - 1));
   assign free_off = {{(OFF_W-16){1'b0}}, req_data.block_addr};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         brk_ff       <= INIT_BREAK;
         chunk_ff     <= CHUNK_RESET;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         brk_ff       <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_CHUNK: chunk_ff <= csr_wdata;
               CSR_LIMIT: limit_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      op_ff     <= op_in;
      asize_ff  <= asize_in;
      bp_ff     <= bp_in;
      sz_ff     <= sz_in;
      ptag_ff   <= ptag_in;
      bs_ff     <= bs_in;
      rem_ff    <= rem_in;
      split_ff  <= split_in;
      w2addr_ff <= w2addr_in;
      wval_ff   <= wval_in;
      gsize_ff  <= gsize_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      logic [OFF_W-1:0] tsum;
      logic [TAG_W-1:0] rem;
      logic             split;

      state_in     = state_ff;
      clr_in       = clr_ff;
      brk_in       = brk_ff;
      op_in        = op_ff;
      asize_in     = asize_ff;
      bp_in        = bp_ff;
      sz_in        = sz_ff;
      ptag_in      = ptag_ff;
      bs_in        = bs_ff;
      rem_in       = rem_ff;
      split_in     = split_ff;
      w2addr_in    = w2addr_ff;
      wval_in      = wval_ff;
      gsize_in     = gsize_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = '0;
      tsum         = '0;
      rem          = '0;
      split        = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            if (clr_ff == IDX_PRO_HDR || clr_ff == IDX_PRO_FTR) begin
               mem_wdata = TAG_PROLOGUE;
            end else if (clr_ff == IDX_CHK_HDR || clr_ff == IDX_CHK_FTR) begin
               mem_wdata = TAG_CHUNK;
            end else if (clr_ff == IDX_EPILOGUE) begin
               mem_wdata = TAG_EPILOGUE;
            end
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in = req_data.func;
               if (req_data.func == FUNC_FREE) begin
                  bp_in    = free_off;
                  mem_addr = word_idx(free_off - OFF_W'(WORD_BYTES));
                  if (req_data.block_addr < 16'(MIN_BLOCK) ||
                      req_data.block_addr[2:0] != 3'b000 ||
                      {1'b0, req_data.block_addr} >= brk_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{payload_addr: '0, status: STATUS_OK};
                  end else begin
                     state_in = S_FREE_HDR;
                  end
               end else if (req_data.req_bytes == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{payload_addr: '0, status: STATUS_ZERO};
               end else begin
                  asize_in = alloc_size;
                  bp_in    = LIST_START;
                  state_in = S_FIT_CHK;
               end
            end
         end
         S_FIT_CHK: begin
            mem_addr = word_idx(bp_ff - OFF_W'(WORD_BYTES));
            if (bp_ff >= OFF_W'(brk_ff)) begin
               state_in = S_GROW;
            end else begin
               state_in = S_FIT_TAG;
            end
         end
         S_FIT_TAG: begin
            if (rd_size == '0) begin
               state_in = S_GROW;
            end else if (!mem_rdata[0] && rd_size >= {1'b0, asize_ff}) begin
               state_in = S_PUT_RD;
            end else begin
               bp_in    = bp_ff + OFF_W'(rd_size);
               state_in = S_FIT_CHK;
            end
         end
         S_GROW: begin
            if (grow_fail) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{payload_addr: '0, status: STATUS_NOSPACE};
               state_in     = S_IDLE;
            end else begin
               mem_we    = 1'b1;
               mem_addr  = word_idx(OFF_W'(brk_ff) - OFF_W'(WORD_BYTES));
               mem_wdata = grow_size;
               gsize_in  = grow_size;
               bp_in     = OFF_W'(brk_ff);
               state_in  = S_GROW_W2;
            end
         end
         S_GROW_W2: begin
            mem_we    = 1'b1;
            mem_addr  = word_idx(bp_ff + OFF_W'(gsize_ff) - OFF_W'(DBL_BYTES));
            mem_wdata = gsize_ff;
            state_in  = S_GROW_W3;
         end
         S_GROW_W3: begin
            // New epilogue just past the grown block.
            mem_we    = 1'b1;
            mem_addr  = word_idx(bp_ff + OFF_W'(gsize_ff) - OFF_W'(WORD_BYTES));
            mem_wdata = TAG_EPILOGUE;
            brk_in    = brk_ff + gsize_ff[REG_W-1:0];
            state_in  = S_MRG_RD1;
         end
         S_MRG_RD1: begin
            mem_addr = word_idx(bp_ff - OFF_W'(WORD_BYTES));
            state_in = S_MRG_RD2;
         end
         S_MRG_RD2: begin
            sz_in    = rd_size;
            mem_addr = word_idx(bp_ff - OFF_W'(DBL_BYTES));
            state_in = S_MRG_RD3;
         end
         S_MRG_RD3: begin
            ptag_in  = mem_rdata;
            mem_addr = word_idx(bp_ff + OFF_W'(sz_ff) - OFF_W'(WORD_BYTES));
            state_in = S_MRG_EV;
         end
         S_MRG_EV: begin
            // Previous footer in ptag_ff, next header on the read data.
            priority if (ptag_ff[0] && mem_rdata[0]) begin
               state_in = S_MRG_DONE;
            end else if (ptag_ff[0]) begin
               tsum      = OFF_W'(sz_ff) + OFF_W'(rd_size);
               mem_addr  = word_idx(bp_ff - OFF_W'(WORD_BYTES));
               w2addr_in = bp_ff + tsum - OFF_W'(DBL_BYTES);
               state_in  = S_MRG_W2;
            end else if (mem_rdata[0]) begin
               tsum      = OFF_W'(sz_ff) + OFF_W'(psize);
               mem_addr  = word_idx(bp_ff + OFF_W'(sz_ff) - OFF_W'(DBL_BYTES));
               w2addr_in = bp_ff - OFF_W'(psize) - OFF_W'(WORD_BYTES);
               bp_in     = bp_ff - OFF_W'(psize);
               state_in  = S_MRG_W2;
            end else begin
               tsum      = OFF_W'(sz_ff) + OFF_W'(psize) + OFF_W'(rd_size);
               mem_addr  = word_idx(bp_ff + OFF_W'(sz_ff) + OFF_W'(rd_size) -
                                    OFF_W'(DBL_BYTES));
               w2addr_in = bp_ff - OFF_W'(psize) - OFF_W'(WORD_BYTES);
               bp_in     = bp_ff - OFF_W'(psize);
               state_in  = S_MRG_W2;
            end
            mem_we    = !(ptag_ff[0] && mem_rdata[0]);
            mem_wdata = tsum[TAG_W-1:0];
            wval_in   = tsum[TAG_W-1:0];
         end
         S_MRG_W2: begin
            mem_we    = 1'b1;
            mem_addr  = word_idx(w2addr_ff);
            mem_wdata = wval_ff;
            state_in  = S_MRG_DONE;
         end
         S_MRG_DONE: begin
            if (op_ff == FUNC_FREE) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{payload_addr: '0, status: STATUS_OK};
               state_in     = S_IDLE;
            end else begin
               state_in = S_PUT_RD;
            end
         end
         S_PUT_RD: begin
            mem_addr = word_idx(bp_ff - OFF_W'(WORD_BYTES));
            state_in = S_PUT_EV;
         end
         S_PUT_EV: begin
            rem      = (rd_size >= {1'b0, asize_ff}) ? rd_size - {1'b0, asize_ff} : '0;
            split    = rem >= TAG_W'(MIN_BLOCK);
            bs_in    = rd_size;
            rem_in   = rem;
            split_in = split;
            mem_we   = 1'b1;
            mem_addr = word_idx(bp_ff - OFF_W'(WORD_BYTES));
            mem_wdata = split ? ({1'b0, asize_ff} | TAG_W'(1)) : (rd_size | TAG_W'(1));
            state_in = S_PUT_W2;
         end
         S_PUT_W2: begin
            mem_we = 1'b1;
            if (split_ff) begin
               mem_addr  = word_idx(bp_ff + OFF_W'(asize_ff) - OFF_W'(DBL_BYTES));
               mem_wdata = {1'b0, asize_ff} | TAG_W'(1);
               state_in  = S_PUT_W3;
            end else begin
               mem_addr     = word_idx(bp_ff + OFF_W'(bs_ff) - OFF_W'(DBL_BYTES));
               mem_wdata    = bs_ff | TAG_W'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{payload_addr: bp_ff[15:0], status: STATUS_OK};
               state_in     = S_IDLE;
            end
         end
         S_PUT_W3: begin
            mem_we    = 1'b1;
            mem_addr  = word_idx(bp_ff + OFF_W'(asize_ff) - OFF_W'(WORD_BYTES));
            mem_wdata = rem_ff;
            state_in  = S_PUT_W4;
         end
         S_PUT_W4: begin
            mem_we       = 1'b1;
            mem_addr     = word_idx(bp_ff + OFF_W'(bs_ff) - OFF_W'(DBL_BYTES));
            mem_wdata    = rem_ff;
            rsp_valid_in = 1'b1;
            rsp_in       = '{payload_addr: bp_ff[15:0], status: STATUS_OK};
            state_in     = S_IDLE;
         end
         S_FREE_HDR: begin
            if (!mem_rdata[0] || rd_size == '0 ||
                (bp_ff + OFF_W'(rd_size) - OFF_W'(WORD_BYTES)) > OFF_W'(brk_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{payload_addr: '0, status: STATUS_OK};
               state_in     = S_IDLE;
            end else begin
               mem_we    = 1'b1;
               mem_addr  = word_idx(bp_ff - OFF_W'(WORD_BYTES));
               mem_wdata = rd_size;
               sz_in     = rd_size;
               state_in  = S_FREE_W2;
            end
         end
         S_FREE_W2: begin
            mem_we    = 1'b1;
            mem_addr  = word_idx(bp_ff + OFF_W'(sz_ff) - OFF_W'(DBL_BYTES));
            mem_wdata = sz_ff;
            state_in  = S_MRG_RD1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result word only ever follows a cycle of work.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff != S_CLEAR))
      else $error("result strobe without preceding work");

   a_break_cap: assert property (@(posedge clock) disable iff (reset)
      brk_ff <= HEAP_CAP)
      else $error("break offset beyond heap size");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |-> rsp_ff.payload_addr == '0)
      else $error("failed request returned an address");

   a_addr_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.payload_addr[2:0] == 3'b000)
      else $error("payload address not double-word aligned");

   a_break_grows_only: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && state_ff != S_CLEAR |-> brk_ff >= $past(brk_ff))
      else $error("break offset moved down");

endmodule
